// File: hdl/uq16_pkg.sv
// Shared types, constants and the pipeline payload struct for the Q16.16 ALU.
package uq16_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned HalfBits = FracBits / 2;
  localparam int unsigned DivBits = WordBits - HalfBits;
  localparam int unsigned DivSteps = 4;
  localparam int unsigned DivStages = WordBits / DivSteps;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [2:0] op_t;

  localparam op_t OpAdd = 3'd0;
  localparam op_t OpSub = 3'd1;
  localparam op_t OpMul = 3'd2;
  localparam op_t OpDiv = 3'd3;
  localparam op_t OpItf = 3'd4;

  typedef struct packed {
    op_t   op;
    word_t res;
    logic  under;
    logic  dz;
    word_t quo;
    word_t rem;
    logic [DivBits-1:0] den;
    word_t num;
  } stage_t;

endpackage

// File: hdl/unsigned_q16_16_alu_core.sv
// Pipelined Q16.16 ALU: add, subtract, multiply, divide and integer to fixed.
// Each accepted beat passes the operand, multiply fold, divide and select stages.
// Throughput: one beat per cycle unless stalled; four quotient bits per divide stage.
// Stalling a valid output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module unsigned_q16_16_alu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  uq16_pkg::op_t       operation_i,
  input  uq16_pkg::word_t     operand_a_i,
  input  uq16_pkg::word_t     operand_b_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output uq16_pkg::word_t     result_value_o,
  output logic                underflow_o,
  output logic                divide_by_zero_o
);
  import uq16_pkg::*;

  localparam int unsigned NStage = DivStages + 3;

  logic   adv;
  logic   [NStage-1:0] vld_q;
  stage_t st_q [NStage];
  stage_t st_d [NStage];

  // Multiplier operands and partial products, stage 0 to stage 1.
  logic [WordBits-1:0] pp_q [4];
  logic [WordBits-1:0] pp_d [4];
  word_t ia, ib, fa, fb;

  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    ia = (operand_a_i & ~word_t'((64'd1 << FracBits) - 1)) >> HalfBits;
    ib = (operand_b_i & ~word_t'((64'd1 << FracBits) - 1)) >> HalfBits;
    fa = operand_a_i & word_t'((64'd1 << FracBits) - 1);
    fb = operand_b_i & word_t'((64'd1 << FracBits) - 1);
    pp_d[0] = word_t'(ia * ib);
    pp_d[1] = word_t'(fa * ib) >> HalfBits;
    pp_d[2] = word_t'(fb * ia) >> HalfBits;
    pp_d[3] = word_t'(fa * fb) >> FracBits;

    st_d[0] = '0;
    st_d[0].op = operation_i;
    st_d[0].num = operand_a_i << HalfBits;
    st_d[0].den = operand_b_i[WordBits-1:HalfBits];
    case (operation_i)
      OpAdd: st_d[0].res = operand_a_i + operand_b_i;
      OpSub: begin
        st_d[0].res = operand_a_i - operand_b_i;
        st_d[0].under = operand_a_i < operand_b_i;
      end
      OpItf: st_d[0].res = operand_a_i << FracBits;
      default: st_d[0].res = '0;
    endcase
    st_d[0].dz = (operation_i == OpDiv) && (operand_b_i[WordBits-1:HalfBits] == '0);

    // Stage 1 folds the multiply sum.
    st_d[1] = st_q[0];
    if (st_q[0].op == OpMul) begin
      st_d[1].res = pp_q[0] + pp_q[1] + pp_q[2] + pp_q[3];
    end

    // Restoring division, DivSteps bits per stage, MSB first.
    for (int s = 0; s < DivStages; s++) begin
      logic [WordBits:0] r;
      r = '0;
      st_d[s+2] = st_q[s+1];
      for (int k = 0; k < DivSteps; k++) begin
        r = {st_d[s+2].rem,
             st_d[s+2].num[WordBits-1-(s*DivSteps+k)]};
        if (r >= {{(WordBits+1-DivBits){1'b0}}, st_d[s+2].den}) begin
          r = r - {{(WordBits+1-DivBits){1'b0}}, st_d[s+2].den};
          st_d[s+2].quo = {st_d[s+2].quo[WordBits-2:0], 1'b1};
        end else begin
          st_d[s+2].quo = {st_d[s+2].quo[WordBits-2:0], 1'b0};
        end
        st_d[s+2].rem = r[WordBits-1:0];
      end
    end

    st_d[NStage-1] = st_q[NStage-2];
    if (st_q[NStage-2].op == OpDiv) begin
      st_d[NStage-1].res = st_q[NStage-2].dz ? '1 : st_q[NStage-2].quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStage-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NStage; i++) st_q[i] <= st_d[i];
      for (int i = 0; i < 4; i++) pp_q[i] <= pp_d[i];
    end
  end

  assign out_valid_o = vld_q[NStage-1];
  assign result_value_o = st_q[NStage-1].res;
  assign underflow_o = st_q[NStage-1].under;
  assign divide_by_zero_o = st_q[NStage-1].dz;

endmodule

// File: hdl/uq16_checker.sv
// Port-level checker for the Q16.16 ALU, bound to the top level.
module uq16_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input uq16_pkg::word_t result_value_o,
  input logic            underflow_o,
  input logic            divide_by_zero_o
);
  import uq16_pkg::*;

  // The input side stalls exactly when a finished beat is held.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i)) else $error("stall mismatch");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o))
    else $error("held beat changed");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(underflow_o && divide_by_zero_o)) else $error("both flags");

  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> result_value_o == '1)
    else $error("divide by zero result");

endmodule

bind unsigned_q16_16_alu_core uq16_checker u_chk (.*);

// File: sim/uq16_alu_checker.sv
// Checker for the Q16.16 ALU: predicts each result and compares it with the output beat.
`timescale 1ns / 1ps
module uq16_alu_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  uq16_pkg::op_t   operation_i,
  input  uq16_pkg::word_t operand_a_i,
  input  uq16_pkg::word_t operand_b_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  uq16_pkg::word_t result_value_i,
  input  logic            underflow_i,
  input  logic            divide_by_zero_i,
  output int              errors_o,
  output int              pending_o
);
  import uq16_pkg::*;

  typedef struct packed {
    word_t value;
    logic  under;
    logic  dz;
  } alu_result_t;

  alu_result_t result_fifo[$];
  int errors = 0;

  assign errors_o  = errors;
  assign pending_o = result_fifo.size();

  function automatic alu_result_t compute_alu(op_t op, word_t a, word_t b);
    alu_result_t r;
    logic [63:0] ia, ib, fa, fb, sum, num, den;
    r = '0;
    case (op)
      OpAdd: r.value = a + b;
      OpSub: begin
        r.value = a - b;
        r.under = a < b;
      end
      OpMul: begin
        ia = {32'd0, a & 32'hFFFF0000} >> 8;
        ib = {32'd0, b & 32'hFFFF0000} >> 8;
        fa = {48'd0, a[15:0]};
        fb = {48'd0, b[15:0]};
        // Each partial product is truncated to a word before its shift.
        sum = ((ia * ib) & 64'hFFFFFFFF)
            + (((fa * ib) & 64'hFFFFFFFF) >> 8)
            + (((fb * ia) & 64'hFFFFFFFF) >> 8)
            + (((fa * fb) & 64'hFFFFFFFF) >> 16);
        r.value = sum[31:0];
      end
      OpDiv: begin
        num = {32'd0, a << 8};
        den = {40'd0, b[31:8]};
        if (den == 0) begin
          r.value = '1;
          r.dz = 1'b1;
        end else begin
          r.value = 32'(num / den);
        end
      end
      OpItf: r.value = a << 16;
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        result_fifo.push_back(compute_alu(operation_i, operand_a_i, operand_b_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_fifo.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result beat: value=%h", result_value_i);
        end else begin
          exp_r = result_fifo.pop_front();
          if (exp_r.value !== result_value_i || exp_r.under !== underflow_i ||
              exp_r.dz !== divide_by_zero_i) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected value=%h uf=%b dz=%b, got value=%h uf=%b dz=%b",
                       exp_r.value, exp_r.under, exp_r.dz,
                       result_value_i, underflow_i, divide_by_zero_i);
          end
        end
      end
    end
  end
endmodule

// File: sim/tb_unsigned_q16_16_alu_core.sv
// Testbench top for the Q16.16 ALU: drives operand beats, random stalls and gives the verdict.
`timescale 1ns / 1ps
module tb_unsigned_q16_16_alu_core;
  import uq16_pkg::*;

  localparam int NumRandom = 900;
  localparam int CalmTail = 150;
  localparam int Latency = 11;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  op_t   operation_i = OpAdd;
  word_t operand_a_i = '0;
  word_t operand_b_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  word_t result_value_o;
  logic  underflow_o;
  logic  divide_by_zero_o;
  int    errors;
  int    pending;
  bit    send_done = 1'b0;
  bit    calm = 1'b0;
  bit    hold_done = 1'b0;

  unsigned_q16_16_alu_core dut (.*);

  uq16_alu_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operation_i,
    .operand_a_i, .operand_b_i, .out_valid_i(out_valid_o), .out_stall_i,
    .result_value_i(result_value_o), .underflow_i(underflow_o),
    .divide_by_zero_i(divide_by_zero_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return word_t'($urandom_range(0, 511));
      3: return {8'd0, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Presents one beat and holds it until accepted; gaps only before a beat.
  task automatic send_beat(op_t op, word_t a, word_t b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    op_t op;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed corners: wraps, underflow, zero divisor, unused codes.
    send_beat(OpAdd, '1, 32'd1);
    send_beat(OpAdd, '0, '0);
    send_beat(OpSub, '0, 32'd1);
    send_beat(OpSub, 32'd5, 32'd5);
    send_beat(OpSub, '1, '0);
    send_beat(OpMul, '1, '1);
    send_beat(OpMul, 32'h00010000, 32'h00018000);
    send_beat(OpMul, 32'h0000FFFF, 32'h0000FFFF);
    send_beat(OpDiv, 32'h00010000, 32'h000000FF);
    send_beat(OpDiv, '1, 32'h00000100);
    send_beat(OpDiv, '1, '1);
    send_beat(OpDiv, '0, 32'h00020000);
    send_beat(OpItf, '1, '1);
    send_beat(OpItf, 32'h00007FFF, '0);
    send_beat(op_t'(5), '1, '1);
    send_beat(op_t'(6), 32'h12345678, 32'h1);
    send_beat(op_t'(7), '0, '1);
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - CalmTail) calm = 1'b1;
      op = ($urandom_range(0, 9) == 0) ? op_t'($urandom_range(5, 7))
                                        : op_t'($urandom_range(0, 4));
      send_beat(op, rand_word(), rand_word());
    end
    in_valid_i <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver: one long hold-off early on, then random stall bursts.
  initial begin
    int burst;
    wait (rst_ni);
    repeat (40) @(posedge clk_i);
    out_stall_i <= 1'b1;
    repeat (60) @(posedge clk_i);
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    wait (send_done);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: unsigned_q16_16_alu_core.f
hdl/uq16_pkg.sv
hdl/unsigned_q16_16_alu_core.sv
hdl/uq16_checker.sv
sim/uq16_alu_checker.sv
sim/tb_unsigned_q16_16_alu_core.sv
